// ===== rtl/core/tbt_pkg.sv =====
package tbt_pkg;

    localparam int unsigned LOG_TABLE_ENTRIES_DEF = 64;

    localparam int LOG_W   = 35;   // log2 in Q30, integer part up to 31
    localparam int RNUM_W  = 42;   // series * sense_uv
    localparam int RDEN_W  = 26;   // supply_uv - sense_uv
    localparam int TNUM_W  = 68;   // a << 31
    localparam int TDEN_W  = 52;   // positive denominator
    localparam int TQUO_W  = 19;   // quotient below 445 * 1024

    localparam logic [23:0] LN2_Q24      = 24'd11629080;
    localparam logic [18:0] TEMP_HIGH    = 19'sd200000;
    localparam logic [18:0] TEMP_LOW     = -19'sd27315;
    localparam logic [16:0] KELVIN_CENTI = 17'd27315;
    localparam logic [8:0]  SAT_QUOT     = 9'd445;

    localparam logic [2:0] REG_SUPPLY_GAIN = 3'd0;
    localparam logic [2:0] REG_SERIES      = 3'd1;
    localparam logic [2:0] REG_NOMINAL     = 3'd2;
    localparam logic [2:0] REG_BETA        = 3'd3;
    localparam logic [2:0] REG_NOMINAL_T   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SUPPLY = 2'd1;
    localparam logic [1:0] ST_ZERO_RES  = 2'd2;
    localparam logic [1:0] ST_SATURATED = 2'd3;

    typedef struct packed {
        logic [31:0] r;
        logic        bad;
        logic        rsat;
        logic        zero;
    } info_t;

    // log2(x0 / 2^30) fraction in Q30 by repeated squaring
    function automatic logic [30:0] rom_entry(input logic [63:0] x0);
        logic [63:0] x;
        logic [30:0] res;
        x   = x0;
        res = '0;
        for (int k = 1; k <= 30; k++)
        begin
            x = (x * x) >> 30;
            if (x >= (64'd1 << 31))
            begin
                x = x >> 1;
                res[30 - k] = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/tbt_div.sv =====
module tbt_div #(
    parameter int NUM_W  = 42,
    parameter int DEN_W  = 26,
    parameter int QUO_W  = 42,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quo,
    output logic [SIDE_W-1:0] side_out
);

    // one quotient bit per stage, restoring; quotient assumed below 2^QUO_W
    logic [QUO_W-1:0]  valid_reg;
    logic [DEN_W-1:0]  rem_reg  [QUO_W];
    logic [QUO_W-1:0]  acc_reg  [QUO_W];
    logic [DEN_W-1:0]  den_reg  [QUO_W];
    logic [SIDE_W-1:0] side_reg [QUO_W];

    genvar k;
    generate
        for (k = 0; k < QUO_W; k++)
        begin : g_stage
            logic              v_p;
            logic [DEN_W-1:0]  rem_p;
            logic [QUO_W-1:0]  acc_p;
            logic [DEN_W-1:0]  den_p;
            logic [SIDE_W-1:0] side_p;
            logic [DEN_W:0]    t;
            logic [DEN_W:0]    tn;
            logic              ge;

            if (k == 0)
            begin : g_first
                assign v_p    = in_valid;
                assign rem_p  = DEN_W'(num >> QUO_W);
                assign acc_p  = num[QUO_W-1:0];
                assign den_p  = den;
                assign side_p = side_in;
            end
            else
            begin : g_next
                assign v_p    = valid_reg[k-1];
                assign rem_p  = rem_reg[k-1];
                assign acc_p  = acc_reg[k-1];
                assign den_p  = den_reg[k-1];
                assign side_p = side_reg[k-1];
            end

            always_comb
            begin
                t  = {rem_p, acc_p[QUO_W-1]};
                ge = (t >= {1'b0, den_p});
                tn = ge ? (t - {1'b0, den_p}) : t;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[k] <= v_p;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= tn[DEN_W-1:0];
                    acc_reg[k]  <= {acc_p[QUO_W-2:0], ge};
                    den_reg[k]  <= den_p;
                    side_reg[k] <= side_p;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[QUO_W-1];
    assign quo       = acc_reg[QUO_W-1];
    assign side_out  = side_reg[QUO_W-1];

endmodule

// ===== rtl/core/tbt_log2.sv =====
module tbt_log2 #(
    parameter int unsigned N = tbt_pkg::LOG_TABLE_ENTRIES_DEF
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [31:0]               x,
    output logic [tbt_pkg::LOG_W-1:0] y
);
    import tbt_pkg::*;

    localparam int IDX_W = $clog2(N + 1);
    localparam int S_W   = 31 + IDX_W;

    logic [30:0] rom_tab [N+1];

    genvar i;
    generate
        for (i = 0; i <= N; i++)
        begin : g_rom
            if (i == N)
            begin : g_top
                assign rom_tab[i] = 31'd1 << 30;
            end
            else
            begin : g_ent
                localparam logic [63:0] X0 = (64'(i) << 30) / N + (64'd1 << 30);
                localparam logic [30:0] ENTRY = rom_entry(X0);
                assign rom_tab[i] = ENTRY;
            end
        end
    endgenerate

    logic [4:0]       n1_reg, n2_reg, n3_reg;
    logic [31:0]      x1_reg;
    logic [IDX_W-1:0] idx2_reg;
    logic [30:0]      rem2_reg, rem3_reg;
    logic [30:0]      lo3_reg, diff3_reg;
    logic [LOG_W-1:0] y_reg;

    logic [4:0]       lead;
    logic [31:0]      norm;
    logic [S_W-1:0]   s;
    logic [61:0]      prod;

    always_comb
    begin
        lead = '0;
        for (int b = 0; b < 32; b++)
        begin
            if (x[b])
            begin
                lead = 5'(b);
            end
        end
        norm = x1_reg << (5'd31 - n1_reg);
        s    = S_W'(norm[30:0]) * S_W'(N);
        prod = 62'(diff3_reg) * 62'(rem3_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg    <= lead;
            x1_reg    <= x;
            n2_reg    <= n1_reg;
            idx2_reg  <= s[S_W-1:31];
            rem2_reg  <= s[30:0];
            n3_reg    <= n2_reg;
            rem3_reg  <= rem2_reg;
            lo3_reg   <= rom_tab[idx2_reg];
            diff3_reg <= rom_tab[idx2_reg + IDX_W'(1)] - rom_tab[idx2_reg];
            y_reg     <= {n3_reg, 30'b0} + LOG_W'(lo3_reg) + LOG_W'(prod >> 31);
        end
    end

    assign y = y_reg;

endmodule

// ===== rtl/core/thermistor_beta_temperature.sv =====
// NTC thermistor temperature by the Beta equation. Each request carries the
// supply sense and thermistor node readings in mV; the result gives the
// temperature in signed centidegrees C, the divider resistance in whole ohms
// and a status code. One request is taken every cycle unless an output stall
// holds the whole pipeline of two bit-per-stage dividers (42 stages for the
// resistance, 19 for the temperature), the 4-stage log2 table lookup and
// the multiply stages around them. Configuration registers must be written
// while the pipeline is empty; the block itself does not enforce this.
module thermistor_beta_temperature #(
    parameter int unsigned LOG_TABLE_ENTRIES = tbt_pkg::LOG_TABLE_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // ref_sense_mv[11:0], sense_mv[23:12]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // temperature_centi_c[18:0], resistance_ohms[50:19]
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data
);
    import tbt_pkg::*;

    localparam int LOG_LAT = 4;

    logic [13:0]        gain_reg;
    logic [19:0]        series_reg;
    logic [19:0]        nominal_reg;
    logic [13:0]        beta_reg;
    logic signed [14:0] t0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg    <= 14'd3350;
            series_reg  <= 20'd20000;
            nominal_reg <= 20'd10000;
            beta_reg    <= 14'd3950;
            t0_reg      <= 15'sd2500;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SUPPLY_GAIN: gain_reg    <= cfg_data[13:0];
                REG_SERIES:      series_reg  <= cfg_data;
                REG_NOMINAL:     nominal_reg <= cfg_data;
                REG_BETA:        beta_reg    <= cfg_data[13:0];
                REG_NOMINAL_T:   t0_reg      <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic m_tvalid_reg;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // stage 1: microvolts
    logic        v1_reg;
    logic [25:0] supply1_reg;
    logic [21:0] sense1_reg;

    // stage 2: resistance division operands
    logic              v2_reg;
    logic              bad2_reg;
    logic [RNUM_W-1:0] num2_reg;
    logic [RDEN_W-1:0] den2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
        end
    end

    logic bad1;
    assign bad1 = (supply1_reg <= 26'(sense1_reg));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            supply1_reg <= 26'(s_tdata[11:0]) * 26'(gain_reg);
            sense1_reg  <= 22'(s_tdata[23:12]) * 22'd1000;
            bad2_reg    <= bad1;
            num2_reg    <= RNUM_W'(series_reg) * RNUM_W'(sense1_reg);
            den2_reg    <= bad1 ? RDEN_W'(1) : (supply1_reg - 26'(sense1_reg));
        end
    end

    logic              vr;
    logic [RNUM_W-1:0] rq;
    logic              badr;

    tbt_div #(
        .NUM_W  (RNUM_W),
        .DEN_W  (RDEN_W),
        .QUO_W  (RNUM_W),
        .SIDE_W (1)
    ) u_div_r (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2_reg),
        .num       (num2_reg),
        .den       (den2_reg),
        .side_in   (bad2_reg),
        .out_valid (vr),
        .quo       (rq),
        .side_out  (badr)
    );

    // stage 3: saturate resistance, log2 operands
    logic        v3_reg;
    info_t       info3_reg;
    logic [31:0] r0_3_reg;
    logic        rsat3;

    assign rsat3 = |rq[RNUM_W-1:32];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            info3_reg.r    <= rsat3 ? 32'hFFFF_FFFF : rq[31:0];
            info3_reg.bad  <= badr;
            info3_reg.rsat <= rsat3;
            info3_reg.zero <= (rq == '0);
            r0_3_reg       <= (nominal_reg == '0) ? 32'd1 : 32'(nominal_reg);
        end
    end

    logic [LOG_W-1:0] lr, lr0;

    tbt_log2 #(.N(LOG_TABLE_ENTRIES)) u_log_r (
        .clk (clk),
        .en  (en),
        .x   (info3_reg.zero ? 32'd1 : info3_reg.r),
        .y   (lr)
    );

    tbt_log2 #(.N(LOG_TABLE_ENTRIES)) u_log_r0 (
        .clk (clk),
        .en  (en),
        .x   (r0_3_reg),
        .y   (lr0)
    );

    logic [LOG_LAT-1:0] vl_reg;
    info_t              infol_reg [LOG_LAT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            infol_reg[0] <= info3_reg;
            for (int j = 1; j < LOG_LAT; j++)
            begin
                infol_reg[j] <= infol_reg[j-1];
            end
        end
    end

    // stages 4..8: ln, denominator, saturation test
    logic v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    info_t info4_reg, info5_reg, info6_reg, info7_reg, info8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            vl_reg <= '0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= vr;
            vl_reg <= {vl_reg[LOG_LAT-2:0], v3_reg};
            v4_reg <= vl_reg[LOG_LAT-1];
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    logic signed [LOG_W:0] delta;
    logic [LOG_W-1:0]      mag4_reg;
    logic                  neg4_reg;
    logic [58:0]           lnprod;
    logic [LOG_W-1:0]      lnmag;
    logic signed [LOG_W:0] lnq5_reg;
    logic [20:0]           bk5_reg;
    logic [15:0]           t0c5_reg;
    logic signed [16:0]    t0c_s;
    logic signed [52:0]    prod6_reg;
    logic [36:0]           a6_reg, a7_reg;
    logic [20:0]           bk6_reg;
    logic signed [53:0]    d7_reg;
    logic                  dpos;
    logic [TDEN_W-1:0]     dm;
    logic [61:0]           thr;
    logic [61:0]           an;
    logic                  tsat8_reg;
    logic [TNUM_W-1:0]     num8_reg;
    logic [TDEN_W-1:0]     den8_reg;

    always_comb
    begin
        delta  = $signed({1'b0, lr}) - $signed({1'b0, lr0});
        lnprod = 59'(mag4_reg) * 59'(LN2_Q24);
        lnmag  = LOG_W'((lnprod + (59'd1 << 23)) >> 24);
        t0c_s  = 17'(t0_reg) + $signed(KELVIN_CENTI);
        dpos   = !d7_reg[53] && (d7_reg != '0);
        dm     = d7_reg[TDEN_W-1:0];
        thr    = 62'(dm) * 62'(SAT_QUOT);
        an     = 62'(a7_reg) << 21;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            info4_reg <= infol_reg[LOG_LAT-1];
            mag4_reg  <= delta[LOG_W] ? LOG_W'(-delta) : delta[LOG_W-1:0];
            neg4_reg  <= delta[LOG_W];

            info5_reg <= info4_reg;
            lnq5_reg  <= neg4_reg ? -$signed({1'b0, lnmag}) : $signed({1'b0, lnmag});
            bk5_reg   <= 21'(beta_reg) * 21'd100;
            t0c5_reg  <= t0c_s[15:0];

            info6_reg <= info5_reg;
            prod6_reg <= 53'(lnq5_reg) * 53'($signed({1'b0, t0c5_reg}));
            a6_reg    <= 37'(bk5_reg) * 37'(t0c5_reg);
            bk6_reg   <= bk5_reg;

            info7_reg <= info6_reg;
            d7_reg    <= 54'(prod6_reg) + $signed({3'b0, bk6_reg, 30'b0});
            a7_reg    <= a6_reg;

            info8_reg <= info7_reg;
            tsat8_reg <= !dpos || (an >= thr);
            num8_reg  <= TNUM_W'(a7_reg) << 31;
            den8_reg  <= dpos ? dm : TDEN_W'(1);
        end
    end

    logic              vt;
    logic [TQUO_W-1:0] tq;
    info_t             info_t_out;
    logic              tsat_t;

    tbt_div #(
        .NUM_W  (TNUM_W),
        .DEN_W  (TDEN_W),
        .QUO_W  (TQUO_W),
        .SIDE_W ($bits(info_t) + 1)
    ) u_div_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v8_reg),
        .num       (num8_reg),
        .den       (den8_reg),
        .side_in   ({info8_reg, tsat8_reg}),
        .out_valid (vt),
        .quo       (tq),
        .side_out  ({info_t_out, tsat_t})
    );

    // output stage: round, offset, clamp, status
    logic [18:0]        tk;
    logic signed [19:0] temp_c;
    logic               clamp;
    logic [18:0]        temp_o;
    logic [31:0]        res_o;
    logic [1:0]         st_o;

    always_comb
    begin
        tk     = 19'((20'(tq) + 20'd1) >> 1);
        temp_c = $signed({1'b0, tk}) - $signed({3'b0, KELVIN_CENTI});
        clamp  = tsat_t || (temp_c > 20'sd200000);
        if (info_t_out.bad)
        begin
            temp_o = '0;
            res_o  = '0;
            st_o   = ST_NO_SUPPLY;
        end
        else if (info_t_out.zero)
        begin
            temp_o = TEMP_HIGH;
            res_o  = '0;
            st_o   = ST_ZERO_RES;
        end
        else
        begin
            temp_o = clamp ? TEMP_HIGH : temp_c[18:0];
            res_o  = info_t_out.r;
            st_o   = (clamp || info_t_out.rsat) ? ST_SATURATED : ST_OK;
        end
    end

    logic [18:0] temp_reg;
    logic [31:0] res_reg;
    logic [1:0]  st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid_reg <= vt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            temp_reg <= temp_o;
            res_reg  <= res_o;
            st_reg   <= st_o;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, res_reg, temp_reg};
    assign m_tuser  = st_reg;

endmodule

// ===== tb/testbench.sv =====
module testbench;
    import tbt_pkg::*;

    localparam int    ENTRIES    = 64;
    localparam longint HOT_LIMIT  = 200000;
    localparam longint COLD_LIMIT = -27315;
    localparam longint ZERO_C_CK  = 27315;
    localparam int    DRAIN_WAIT = 120;

    typedef struct packed {
        logic [18:0] temp;
        logic [31:0] ohms;
        logic [1:0]  st;
    } reading_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [19:0] cfg_data;

    thermistor_beta_temperature dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // shadow of the configuration
    logic [13:0]        gain_sh;
    logic [19:0]        series_sh;
    logic [19:0]        nominal_sh;
    logic [13:0]        beta_sh;
    logic signed [14:0] t0_sh;

    longint unsigned log_frac [0:ENTRIES];

    logic [23:0] pending_readings[$];
    reading_t    expected_readings[$];
    int          errors;
    int          n_results;
    int          n_sent;
    int          n_sat, n_nosup, n_zero;
    int          burst_left, gap_left;
    int          stall_left, holdoff_left;
    bit          holdoff_done;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint unsigned frac_entry(int i);
        longint unsigned x, res;
        res = 0;
        if (i >= ENTRIES)
            return 64'd1 << 30;
        x = (64'd1 << 30) + ((longint'(i) << 30) / ENTRIES);
        for (int k = 1; k <= 30; k++)
        begin
            x = (x * x) >> 30;
            if (x >= (64'd1 << 31))
            begin
                x = x >> 1;
                res |= 64'd1 << (30 - k);
            end
        end
        return res;
    endfunction

    function automatic longint unsigned log2_fixed(longint unsigned x);
        int n;
        longint unsigned f, s, idx, rm, lo, hi;
        n = 31;
        while (n > 0 && x[n] == 1'b0)
            n--;
        f   = (x << (31 - n)) & 64'hFFFF_FFFF;
        s   = (f - (64'd1 << 31)) * ENTRIES;
        idx = s >> 31;
        rm  = s & 64'h7FFF_FFFF;
        if (idx >= ENTRIES)
            idx = ENTRIES - 1;
        lo = log_frac[idx];
        hi = log_frac[idx + 1];
        return (longint'(n) << 30) + lo + (((hi - lo) * rm) >> 31);
    endfunction

    function automatic reading_t thermistor_reading(logic [23:0] d);
        reading_t        o;
        longint unsigned supply, sns, r, r0, mag, lnmag, a, q1, rm, q;
        longint          delta, lnq, t0c, den, temp;
        supply = longint'(d[11:0]) * gain_sh;
        sns    = longint'(d[23:12]) * 1000;
        o.st   = ST_OK;
        if (supply <= sns)
        begin
            o.temp = '0; o.ohms = '0; o.st = ST_NO_SUPPLY;
            return o;
        end
        r = (longint'(series_sh) * sns) / (supply - sns);
        if (r > 64'hFFFF_FFFF)
        begin
            r = 64'hFFFF_FFFF;
            o.st = ST_SATURATED;
        end
        if (r == 0)
        begin
            o.temp = 19'(HOT_LIMIT); o.ohms = '0; o.st = ST_ZERO_RES;
            return o;
        end
        r0    = (nominal_sh != 0) ? nominal_sh : 1;
        delta = longint'(log2_fixed(r)) - longint'(log2_fixed(r0));
        mag   = (delta < 0) ? -delta : delta;
        lnmag = (mag * LN2_Q24 + (64'd1 << 23)) >> 24;
        lnq   = (delta < 0) ? -longint'(lnmag) : longint'(lnmag);
        t0c   = longint'(t0_sh) + ZERO_C_CK;
        den   = lnq * t0c + longint'((longint'(beta_sh) * 100) << 30);
        if (den <= 0)
        begin
            temp = HOT_LIMIT; o.st = ST_SATURATED;
        end
        else
        begin
            a  = longint'(beta_sh) * 100 * t0c;
            q1 = (a << 21) / den;
            rm = (a << 21) % den;
            if (q1 >= 445)
            begin
                temp = HOT_LIMIT; o.st = ST_SATURATED;
            end
            else
            begin
                q    = (q1 << 10) + ((rm << 10) / den);
                temp = longint'((q + 1) >> 1) - ZERO_C_CK;
                if (temp > HOT_LIMIT)
                begin
                    temp = HOT_LIMIT; o.st = ST_SATURATED;
                end
                else if (temp < COLD_LIMIT)
                begin
                    temp = COLD_LIMIT; o.st = ST_SATURATED;
                end
            end
        end
        o.temp = temp[18:0];
        o.ohms = r[31:0];
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH result %0d %s: got %0d want %0d", n_results, what, got, want);
        errors++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [19:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SUPPLY_GAIN: gain_sh    = v[13:0];
            REG_SERIES:      series_sh  = v;
            REG_NOMINAL:     nominal_sh = v;
            REG_BETA:        beta_sh    = v[13:0];
            REG_NOMINAL_T:   t0_sh      = v[14:0];
            default: ;
        endcase
    endtask

    task automatic set_all(logic [19:0] g, logic [19:0] s, logic [19:0] n,
                           logic [19:0] b, logic [19:0] t);
        write_reg(REG_SUPPLY_GAIN, g);
        write_reg(REG_SERIES, s);
        write_reg(REG_NOMINAL, n);
        write_reg(REG_BETA, b);
        write_reg(REG_NOMINAL_T, t);
    endtask

    task automatic drain();
        wait (pending_readings.size() == 0 && expected_readings.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic logic [23:0] pair(int rf, int sn);
        return {sn[11:0], rf[11:0]};
    endfunction

    // mostly readings that land below the supply, so the Beta path runs
    task automatic random_readings(int count);
        int rf, sn, top;
        for (int i = 0; i < count; i++)
        begin
            rf = $urandom_range(0, 4095);
            case ($urandom_range(0, 9))
                0, 1: sn = $urandom_range(0, 4095);
                2:    sn = $urandom_range(0, 3);
                default:
                begin
                    top = (rf * gain_sh) / 1000;
                    if (top > 4095) top = 4095;
                    sn = $urandom_range(0, top);
                end
            endcase
            pending_readings.push_back(pair(rf, sn));
        end
    endtask

    // sender: bursts and gaps, held steady while a request is waiting
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_readings.push_back(thermistor_reading(s_tdata));
                void'(pending_readings.pop_front());
                n_sent++;
            end
            if (s_tvalid && !s_tready)
                s_tvalid <= 1'b1;
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_readings.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_readings[0];
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // one long hold-off, counted in cycles, while requests are still queued
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_left <= 0;
            holdoff_done <= 1'b0;
        end
        else if (!holdoff_done && n_results >= 100)
        begin
            holdoff_done <= 1'b1;
            holdoff_left <= 400;
        end
        else if (holdoff_left > 0)
            holdoff_left <= holdoff_left - 1;
    end

    // receiver: own stall pattern plus the hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                reading_t got, want;
                got = {m_tdata[18:0], m_tdata[50:19], m_tuser};
                if (expected_readings.size() == 0)
                    report_mismatch("unexpected result", longint'(m_tdata[50:0]), 0);
                else
                begin
                    want = expected_readings.pop_front();
                    if (got.temp != want.temp)
                        report_mismatch("temperature", signed'(got.temp), signed'(want.temp));
                    if (got.ohms != want.ohms)
                        report_mismatch("resistance", got.ohms, want.ohms);
                    if (got.st != want.st)
                        report_mismatch("status", got.st, want.st);
                    case (want.st)
                        ST_SATURATED: n_sat++;
                        ST_NO_SUPPLY: n_nosup++;
                        ST_ZERO_RES:  n_zero++;
                        default: ;
                    endcase
                end
                n_results++;
            end
            if (holdoff_left > 0)
                m_tready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if ((n_results / 150) % 3 != 2 && $urandom_range(0, 7) == 0)
                    stall_left <= $urandom_range(1, 8);
            end
        end
    end

    initial
    begin
        errors = 0; n_results = 0; n_sent = 0;
        n_sat = 0; n_nosup = 0; n_zero = 0;
        for (int i = 0; i <= ENTRIES; i++)
            log_frac[i] = frac_entry(i);
        gain_sh = 3350; series_sh = 20000; nominal_sh = 10000;
        beta_sh = 3950; t0_sh = 2500;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: extremes of both readings
        pending_readings.push_back(pair(0, 0));
        pending_readings.push_back(pair(4095, 0));
        pending_readings.push_back(pair(4095, 4095));
        pending_readings.push_back(pair(0, 4095));
        pending_readings.push_back(pair(4095, 1));
        pending_readings.push_back(pair(1000, 3349));
        pending_readings.push_back(pair(1000, 1650));
        pending_readings.push_back(pair(2048, 2048));
        pending_readings.push_back(pair(1365, 2730));
        drain();

        // supply one microvolt above the node: resistance saturates
        set_all(20'd3001, 20'd1000000, 20'd1, 20'd1000, 20'(-4000));
        pending_readings.push_back(pair(1001, 3004));
        pending_readings.push_back(pair(1001, 3003));
        pending_readings.push_back(pair(4095, 4094));
        pending_readings.push_back(pair(4095, 2));
        drain();

        // zero nominal resistance and zero beta
        set_all(20'd10000, 20'd1, 20'd0, 20'd0, 20'd15000);
        pending_readings.push_back(pair(100, 500));
        pending_readings.push_back(pair(4095, 4000));
        pending_readings.push_back(pair(4095, 1));
        drain();

        // field extremes
        set_all(20'h3FFF, 20'hFFFFF, 20'hFFFFF, 20'h3FFF, 20'h3FFF);
        pending_readings.push_back(pair(4095, 4095));
        pending_readings.push_back(pair(1, 1));
        pending_readings.push_back(pair(4095, 100));
        drain();
        set_all(20'd1000, 20'd1000000, 20'd1000000, 20'd10000, 20'h4000);
        pending_readings.push_back(pair(4095, 4000));
        pending_readings.push_back(pair(2000, 1000));
        drain();

        set_all(20'd3350, 20'd20000, 20'd10000, 20'd3950, 20'd2500);
        random_readings(300);
        drain();
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph % 3 == 0)
                set_all(20'($urandom_range(0, 16383)), 20'($urandom_range(0, 1048575)),
                        20'($urandom_range(0, 1048575)), 20'($urandom_range(0, 16383)),
                        20'($urandom_range(0, 32767)));
            else
                set_all(20'($urandom_range(1000, 10000)), 20'($urandom_range(1, 1000000)),
                        20'($urandom_range(1, 1000000)), 20'($urandom_range(1000, 10000)),
                        20'($signed($urandom_range(0, 19000)) - 4000));
            random_readings(140);
            drain();
        end

        $display("%0d readings sent, %0d results checked over several settings", n_sent, n_results);
        $display("no supply %0d, zero resistance %0d, saturated %0d",
                 n_nosup, n_zero, n_sat);
        if (errors == 0)
            $display("thermistor_beta_temperature verification clean");
        else
            $display("thermistor_beta_temperature verification failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("thermistor_beta_temperature verification failed");
        $finish;
    end

endmodule

// ===== thermistor_beta_temperature.f =====
rtl/core/tbt_pkg.sv
rtl/core/tbt_div.sv
rtl/core/tbt_log2.sv
rtl/core/thermistor_beta_temperature.sv
tb/testbench.sv
